// ===== rtl/v3mmq_pkg.sv =====
// ----------------------------------------------------------------------------
// v3mmq_pkg
// Types and constants shared by the vec3 millimetre quantizer.
// ----------------------------------------------------------------------------
package v3mmq_pkg;

    localparam int unsigned FP_W   = 32;
    localparam int unsigned MM_W   = 32;
    localparam int unsigned PROD_W = 34;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [FP_W-1:0] x_bits;
        logic [FP_W-1:0] y_bits;
        logic [FP_W-1:0] z_bits;
    } vec_in_t;

    typedef struct packed {
        logic signed [MM_W-1:0] x_mm;
        logic signed [MM_W-1:0] y_mm;
        logic signed [MM_W-1:0] z_mm;
        logic        [1:0]      status;
    } vec_out_t;

    // per-component result
    typedef struct packed {
        logic            nonfinite;
        logic            range_err;
        logic [MM_W-1:0] value;
    } comp_res_t;

endpackage

// ===== rtl/v3mmq_comp.sv =====
// ----------------------------------------------------------------------------
// v3mmq_comp
// One component: float32 times 1000, rounded half away from zero to int32.
// ----------------------------------------------------------------------------
module v3mmq_comp
    import v3mmq_pkg::*;
(
    input  logic [FP_W-1:0] bits,
    output comp_res_t       res
);

    logic              sign;
    logic [7:0]        expf;
    logic [23:0]       man;
    logic [PROD_W-1:0] prod;
    logic [7:0]        shift;
    logic [5:0]        sh;
    logic [PROD_W-1:0] ip;
    logic [PROD_W-1:0] frac;
    logic [PROD_W-1:0] half;
    logic [PROD_W-1:0] limit;
    logic [MM_W:0]     mag;
    logic              big;
    logic              tiny;

    always_comb
    begin
        sign  = bits[31];
        expf  = bits[30:23];
        man   = {(expf != 8'd0), bits[22:0]};
        big   = (expf >= 8'd150) && (expf != 8'hFF);
        shift = (expf == 8'd0) ? 8'd149 : (8'd150 - expf);
        tiny  = (shift >= 8'd35);
        sh    = shift[5:0];
        // x*1000 = x*1024 - x*16 - x*8
        prod  = ({10'd0, man} << 10) - ({10'd0, man} << 4) - ({10'd0, man} << 3);
        ip    = prod >> sh;
        half  = (sh == 6'd0) ? '0 : ({{(PROD_W-1){1'b0}}, 1'b1} << (sh - 6'd1));
        frac  = prod & ((half << 1) - {{(PROD_W-1){1'b0}}, 1'b1});
        limit = sign ? {2'b0, 32'h8000_0000} : {2'b0, 32'h7FFF_FFFF};
        mag   = ip[MM_W:0] + {{MM_W{1'b0}}, (sh != 6'd0) && (frac >= half)};

        res.nonfinite = (expf == 8'hFF);
        res.range_err = big || (!tiny && ((ip > limit) || (ip == limit && frac != '0)));
        if (tiny || big)
        begin
            res.value = '0;
        end
        else if (sign)
        begin
            res.value = -mag[MM_W-1:0];
        end
        else
        begin
            res.value = mag[MM_W-1:0];
        end
    end

endmodule

// ===== rtl/vec3_float_to_millimetre_quantizer_top.sv =====
// The result strobe (done) follows the accepted start beat through in_vld_reg and out_vld_reg.
// Throughput: one vector per cycle; busy is never high.
// Path: input register, three constant-multiply quantizers, result register.
// Reset (rst_n, async low) clears the valid pipeline; no results are lost
// since the receiver cannot stall.
// ----------------------------------------------------------------------------
// vec3_float_to_millimetre_quantizer_top
// Converts a float32 vector to signed millimetre integers with status.
// ----------------------------------------------------------------------------
module vec3_float_to_millimetre_quantizer_top
    import v3mmq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  vec_in_t  in_data,
    output logic     done,
    output vec_out_t result
);

    vec_in_t   in_reg;
    logic      in_vld_reg;
    vec_out_t  out_reg;
    vec_out_t  out_next;
    logic      out_vld_reg;
    comp_res_t rx, ry, rz;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= in_data;
        end
        if (in_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    v3mmq_comp u_x (.bits(in_reg.x_bits), .res(rx));
    v3mmq_comp u_y (.bits(in_reg.y_bits), .res(ry));
    v3mmq_comp u_z (.bits(in_reg.z_bits), .res(rz));

    always_comb
    begin
        out_next = '0;
        if (rx.nonfinite || ry.nonfinite || rz.nonfinite)
        begin
            out_next.status = ST_INVALID;
        end
        else if (rx.range_err || ry.range_err || rz.range_err)
        begin
            out_next.status = ST_RANGE;
        end
        else
        begin
            out_next.x_mm   = rx.value;
            out_next.y_mm   = ry.value;
            out_next.z_mm   = rz.value;
            out_next.status = ST_OK;
        end
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done) else $error("result beat missing");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |->
        result.x_mm == 0 && result.y_mm == 0 && result.z_mm == 0)
        else $error("error beat has nonzero values");
    a_no_st3: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != 2'd3) else $error("bad status");
`endif

endmodule
